>>> hw/rtl/cdc_pkg.sv
// Shared types, command codes and calendar helpers for the date counter.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package cdc_pkg;

    // Command codes carried in the request
    typedef enum logic [2:0] {
        CMD_SET  = 3'd0,
        CMD_NEXT = 3'd1,
        CMD_PREV = 3'd2,
        CMD_ADD  = 3'd3,
        CMD_SUB  = 3'd4
    } cmd_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX,
        ST_WALK,
        ST_DONE
    } state_t;

    // Request payload
    typedef struct packed {
        logic [2:0]  command;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [15:0] set_year;
        logic [15:0] day_count;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
        logic        leap_year;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start_set;
        logic start_add;
        logic start_sub;
        logic one_day;
        logic fix_set;
        logic walk;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_done;
    } dp_stat_t;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int WORK_W  = 18;

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    // Divisibility by 25 on 16 bits: multiply by the modular inverse of 25,
    // the product is a multiple iff it falls at or below 65535 / 25.
    localparam logic [15:0] INV25_MOD16 = 16'd23593;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // Gregorian leap rule: by 4, not by 100 unless by 400.
    // With the year a multiple of 4, by 100 means by 25 and by 400 means
    // by 25 and by 16.
    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic        div25;
        prod  = 32'(y) * 32'(INV25_MOD16);
        div25 = (prod[15:0] <= DIV25_LIMIT);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'h0));
    endfunction

    // Length of a month; a code outside 1..12 reads as January
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cdc_ctrl.sv
// Controller of the date counter: sequences set, walk and result transfer.
// Depends on cdc_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module cdc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic [2:0]        req_command,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output cdc_pkg::dp_cmd_t       cmd,
    input  wire cdc_pkg::dp_stat_t stat
);
    import cdc_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   req_xfer;
    logic   out_free;
    cmd_t   op;

    assign op        = cmd_t'(req_command);
    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    unique case (op)
                        CMD_SET:                    state_next = ST_FIX;
                        CMD_NEXT, CMD_PREV,
                        CMD_ADD, CMD_SUB:           state_next = ST_WALK;
                        default:                    state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIX:  state_next = ST_DONE;
            ST_WALK:
            begin
                if (stat.walk_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd.start_set = (op == CMD_SET);
                    cmd.start_add = (op == CMD_NEXT) || (op == CMD_ADD);
                    cmd.start_sub = (op == CMD_PREV) || (op == CMD_SUB);
                    cmd.one_day   = (op == CMD_NEXT) || (op == CMD_PREV);
                end
            end
            ST_FIX:  cmd.fix_set  = 1'b1;
            ST_WALK: cmd.walk     = 1'b1;
            ST_DONE: cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

    // Response valid: set on load, cleared on transfer
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cdc_dpath.sv
// Datapath of the date counter: date registers, day work register, month
// walk step and response register. Depends on cdc_pkg.
`default_nettype none

module cdc_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cdc_pkg::req_t    req,
    input  wire cdc_pkg::dp_cmd_t cmd,
    output cdc_pkg::dp_stat_t     stat,
    output cdc_pkg::rsp_t         rsp
);
    import cdc_pkg::*;

    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic               sub_reg, sub_next;
    rsp_t               rsp_reg;

    logic               leap_cur;
    logic [DAY_W-1:0]   len_cur;
    logic [MONTH_W-1:0] prev_month;
    logic [DAY_W-1:0]   len_prev;
    logic [15:0]        count;
    logic               add_done;
    logic               sub_done;
    logic [DAY_W-1:0]   sd;
    logic [MONTH_W-1:0] sm;
    logic [YEAR_W-1:0]  sy;

    // Calendar facts of the held month
    assign leap_cur   = is_leap(year_reg);
    assign len_cur    = month_len(month_reg, leap_cur);
    assign prev_month = (month_reg <= MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
    // previous month is February only when the held month is March, same year
    assign len_prev   = month_len(prev_month, leap_cur);

    assign count    = cmd.one_day ? 16'd1 : req.day_count;
    assign add_done = ($signed(work_reg) <= $signed({{(WORK_W-DAY_W){1'b0}}, len_cur}));
    assign sub_done = ($signed(work_reg) >= $signed(WORK_W'(1)));
    assign stat.walk_done = sub_reg ? sub_done : add_done;

    // Set operands clamped to the calendar
    assign sd = (req.set_day == '0) ? 5'd1 : req.set_day;
    assign sm = (req.set_month == '0) ? MONTH_JAN :
                (req.set_month > MONTH_DEC) ? MONTH_DEC : req.set_month;
    assign sy = (req.set_year == '0) ? 16'd1 : req.set_year;

    // Date and work register update
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        work_next  = work_reg;
        sub_next   = sub_reg;
        priority if (cmd.start_set)
        begin
            day_next   = sd;
            month_next = sm;
            year_next  = sy;
        end
        else if (cmd.start_add)
        begin
            work_next = WORK_W'(day_reg) + WORK_W'(count);
            sub_next  = 1'b0;
        end
        else if (cmd.start_sub)
        begin
            work_next = WORK_W'(day_reg) - WORK_W'(count);
            sub_next  = 1'b1;
        end
        else if (cmd.fix_set)
        begin
            if (day_reg > len_cur)
                day_next = len_cur;
        end
        else if (cmd.walk)
        begin
            if (stat.walk_done)
                day_next = work_reg[DAY_W-1:0];
            else if (sub_reg)
            begin
                // back one month, then add its length
                month_next = prev_month;
                if (month_reg <= MONTH_JAN)
                    year_next = year_reg - 16'd1;
                work_next = work_reg + WORK_W'(len_prev);
            end
            else
            begin
                // consume the held month, then forward one month
                work_next = work_reg - WORK_W'(len_cur);
                if (month_reg >= MONTH_DEC)
                begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + 16'd1;
                end
                else
                    month_next = month_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= 5'd1;
            month_reg <= MONTH_JAN;
            year_reg  <= 16'd1;
            sub_reg   <= 1'b0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            sub_reg   <= sub_next;
        end
    end

    // Work register and response payload need no reset
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (cmd.load_out)
        begin
            rsp_reg.cur_day   <= day_reg;
            rsp_reg.cur_month <= month_reg;
            rsp_reg.cur_year  <= year_reg;
            rsp_reg.leap_year <= leap_cur;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/calendar_date_counter_unit.sv
// Top level of the Gregorian date counter: controller plus datapath.
// Depends on cdc_pkg, cdc_ctrl and cdc_dpath.
//
// Holds one date (reset 1 January of year 1) and takes one command per
// request transfer: set, next day, previous day, add day_count days or
// subtract day_count days; codes 5..7 just report the held date. Every
// request yields exactly one response with the new date and its leap flag.
// One request is in work at a time. After the request transfer, set passes
// the fix state, which clamps the day to the month length; next/previous
// day, add and subtract pass the walk state, which crosses one month
// boundary per step until the day fits; reserved codes go straight to the
// done state, which loads the response register. The month walk steps one
// month per cycle through one leap unit and month-length lookups for the
// held and the previous month (up to about 2160 months for 65535 days). A
// result still held in the output register delays the load until that
// register is free. The response sits in an output register, so a new request
// is taken while it waits; the next request can be accepted in the cycle after the load.
`default_nettype none

module calendar_date_counter_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cdc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output cdc_pkg::rsp_t      rsp
);
    import cdc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    cdc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_command (req.command),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .cmd         (cmd),
        .stat        (stat)
    );

    cdc_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

>>> tb/calendar_date_checker.sv
// Date checker: watches both channels of the date counter, predicts each response
// and compares it field by field. Depends on cdc_pkg.
module calendar_date_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  cdc_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  cdc_pkg::rsp_t rsp,
    output int            mismatch_count,
    output int            dates_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdc_pkg::*;

    localparam int MAX_PRINTED = 40;

    // Predicted date, tracked in step with the block
    int          held_day;
    logic [3:0]  held_month;
    logic [15:0] held_year;

    rsp_t expected_dates[$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("%0t ns  mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic bit year_is_leap(input logic [15:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in(input logic [3:0] m, input logic [15:0] y);
        case (m)
            4'd2:                    return year_is_leap(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    task automatic month_forward();
        if (held_month >= 4'd12)
        begin
            held_month = 4'd1;
            held_year  = held_year + 16'd1;
        end
        else
        begin
            held_month = held_month + 4'd1;
        end
    endtask

    task automatic month_back();
        if (held_month <= 4'd1)
        begin
            held_month = 4'd12;
            held_year  = held_year - 16'd1;
        end
        else
        begin
            held_month = held_month - 4'd1;
        end
    endtask

    // Apply one command to the held date and return the response it yields
    task automatic apply_command(input req_t r, output rsp_t next);
        int          d;
        logic [3:0]  m;
        logic [15:0] y;
        case (r.command)
            CMD_SET:
            begin
                d = r.set_day;
                if (d < 1) d = 1;
                if (d > 31) d = 31;
                m = r.set_month;
                if (m < 4'd1) m = 4'd1;
                if (m > 4'd12) m = 4'd12;
                y = (r.set_year == 16'd0) ? 16'd1 : r.set_year;
                if (d > days_in(m, y)) d = days_in(m, y);
                held_day   = d;
                held_month = m;
                held_year  = y;
            end
            CMD_NEXT:
            begin
                if (held_day >= days_in(held_month, held_year))
                begin
                    held_day = 1;
                    month_forward();
                end
                else
                begin
                    held_day++;
                end
            end
            CMD_PREV:
            begin
                if (held_day <= 1)
                begin
                    month_back();
                    held_day = days_in(held_month, held_year);
                end
                else
                begin
                    held_day--;
                end
            end
            CMD_ADD:
            begin
                d = held_day + int'(r.day_count);
                while (d > days_in(held_month, held_year))
                begin
                    d -= days_in(held_month, held_year);
                    month_forward();
                end
                held_day = d;
            end
            CMD_SUB:
            begin
                // landing on day zero or below borrows whole months
                d = held_day - int'(r.day_count);
                while (d < 1)
                begin
                    month_back();
                    d += days_in(held_month, held_year);
                end
                held_day = d;
            end
            default:
            begin
                // reserved codes only report the held date
            end
        endcase
        next.cur_day   = 5'(held_day);
        next.cur_month = held_month;
        next.cur_year  = held_year;
        next.leap_year = year_is_leap(held_year);
    endtask

    // Pop on response transfers, push on request transfers
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            held_day   = 1;
            held_month = 4'd1;
            held_year  = 16'd1;
            expected_dates.delete();
            dates_pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    report_mismatch($sformatf("response %0d/%0d/%0d with no request waiting",
                                              rsp.cur_day, rsp.cur_month, rsp.cur_year));
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (rsp.cur_day !== want.cur_day)
                        report_mismatch($sformatf("cur_day got %0d want %0d",
                                                  rsp.cur_day, want.cur_day));
                    if (rsp.cur_month !== want.cur_month)
                        report_mismatch($sformatf("cur_month got %0d want %0d",
                                                  rsp.cur_month, want.cur_month));
                    if (rsp.cur_year !== want.cur_year)
                        report_mismatch($sformatf("cur_year got %0d want %0d",
                                                  rsp.cur_year, want.cur_year));
                    if (rsp.leap_year !== want.leap_year)
                        report_mismatch($sformatf("leap_year got %0b want %0b (year %0d)",
                                                  rsp.leap_year, want.leap_year,
                                                  want.cur_year));
                end
            end
            if (req_valid && !req_stall)
            begin
                apply_command(req, want);
                expected_dates.push_back(want);
            end
            dates_pending <= expected_dates.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the date counter testbench: clock, reset, request and response pacing.
// Depends on cdc_pkg, calendar_date_counter_unit and calendar_date_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cdc_pkg::*;

    localparam int RANDOM_ITEMS     = 250;
    localparam int HOLD_AT_ITEM     = 80;
    localparam int DRAIN_AT_ITEM    = 160;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 40;

    // Codes the block does not define; they only report the held date
    localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int mismatch_count;
    int dates_pending;
    bit long_hold_request;

    calendar_date_counter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    calendar_date_checker i_date_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .dates_pending  (dates_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic req_t make_req(input logic [2:0] cmd, input logic [4:0] day,
                                      input logic [3:0] month, input logic [15:0] year,
                                      input logic [15:0] count);
        req_t r;
        r.command   = cmd;
        r.set_day   = day;
        r.set_month = month;
        r.set_year  = year;
        r.day_count = count;
        return r;
    endfunction

    // Random command; unused fields carry noise
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.set_day   = 5'($urandom);
        r.set_month = 4'($urandom);
        r.set_year  = 16'($urandom);
        r.day_count = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            r.command = CMD_SET;
            if ($urandom_range(0, 4) != 0)
                r.set_month = 4'($urandom_range(1, 12));
            case ($urandom_range(0, 4))
                0: r.set_year = 16'($urandom_range(1890, 2110));
                1: r.set_year = 16'($urandom_range(0, 655) * 100);
                2: r.set_year = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2))
                                                           : 16'($urandom_range(65533, 65535));
                default: ;
            endcase
        end
        else if (pick < 40)
            r.command = CMD_NEXT;
        else if (pick < 60)
            r.command = CMD_PREV;
        else if (pick < 96)
        begin
            r.command = (pick < 78) ? CMD_ADD : CMD_SUB;
            // mostly short walks, a few across the whole count range
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r.day_count = 16'($urandom_range(0, 62));
                6, 7:             r.day_count = 16'($urandom_range(0, 1500));
                8:                r.day_count = 16'($urandom);
                default:          r.day_count = 16'($urandom_range(60000, 65535));
            endcase
        end
        else
            r.command = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        return r;
    endfunction

    // Hold the request until a transfer happens
    task automatic send_request(input req_t item);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (dates_pending != 0)
            @(posedge clk);
    endtask

    // Response side: stall stretches of random style, plus one long hold-off
    initial
    begin
        int unsigned style;
        int unsigned stretch;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_request)
            begin
                repeat (LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    rsp_stall <= 1'b1;
                end
                long_hold_request = 1'b0;
            end
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(8, 60);
            repeat (stretch)
            begin
                @(posedge clk);
                case (style)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= ~rsp_stall;
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int          sent;
        int unsigned burst;
        int unsigned gap;
        bit          held_off;
        bit          drained;
        rst_n             = 1'b0;
        req_valid         = 1'b0;
        req               = '0;
        long_hold_request = 1'b0;
        held_off          = 1'b0;
        drained           = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range clamps, leap rules, month and year wraps
        send_request(make_req(CMD_SET, 5'd0, 4'd0, 16'd0, 16'd0));
        send_request(make_req(CMD_SET, 5'd31, 4'd15, 16'd65535, 16'd0));
        send_request(make_req(CMD_NEXT, 5'd0, 4'd0, 16'd0, 16'd0));   // year wraps to 0
        send_request(make_req(CMD_PREV, 5'd0, 4'd0, 16'd0, 16'd0));   // and back to 65535
        send_request(make_req(CMD_SET, 5'd31, 4'd2, 16'd2000, 16'd0));
        send_request(make_req(CMD_NEXT, 5'd0, 4'd0, 16'd0, 16'd0));
        send_request(make_req(CMD_PREV, 5'd0, 4'd0, 16'd0, 16'd0));
        send_request(make_req(CMD_SET, 5'd29, 4'd2, 16'd1900, 16'd0));
        send_request(make_req(CMD_SET, 5'd31, 4'd9, 16'd2023, 16'd0));
        send_request(make_req(CMD_SET, 5'd31, 4'd1, 16'd2023, 16'd0));
        send_request(make_req(CMD_SUB, 5'd0, 4'd0, 16'd0, 16'd31));   // lands on day zero
        send_request(make_req(CMD_ADD, 5'd0, 4'd0, 16'd0, 16'd1));
        send_request(make_req(CMD_ADD, 5'd0, 4'd0, 16'd0, 16'd0));
        send_request(make_req(CMD_SUB, 5'd0, 4'd0, 16'd0, 16'd0));
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
            send_request(make_req(3'(c), 5'd9, 4'd9, 16'd9, 16'd9));
        send_request(make_req(CMD_SET, 5'd1, 4'd1, 16'd1, 16'd0));
        send_request(make_req(CMD_PREV, 5'd0, 4'd0, 16'd0, 16'd0));   // into year 0
        send_request(make_req(CMD_SUB, 5'd0, 4'd0, 16'd0, 16'd65535));
        send_request(make_req(CMD_ADD, 5'd0, 4'd0, 16'd0, 16'd65535));
        send_request(make_req(CMD_SET, 5'd28, 4'd12, 16'd65535, 16'd0));
        send_request(make_req(CMD_ADD, 5'd0, 4'd0, 16'd0, 16'd400));
        send_request(make_req(CMD_SUB, 5'd0, 4'd0, 16'd0, 16'd800));
        wait_for_results();

        // Random bursts with gaps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            gap   = 0;
            case ($urandom_range(0, 3))
                1:       gap = $urandom_range(1, 3);
                2:       gap = $urandom_range(4, 20);
                3:       gap = $urandom_range(30, 120);
                default: ;
            endcase
            if (!held_off && sent >= HOLD_AT_ITEM)
            begin
                // keep offering while responses are held back
                long_hold_request = 1'b1;
                held_off          = 1'b1;
                burst             = 12;
            end
            if (!drained && sent >= DRAIN_AT_ITEM)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            repeat (burst)
            begin
                if (sent < RANDOM_ITEMS)
                begin
                    send_request(random_request());
                    sent++;
                end
            end
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && dates_pending == 0)
            $display("[calendar_date_counter_unit] OK");
        else
            $display("[calendar_date_counter_unit] ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #50_000_000;
        $display("[calendar_date_counter_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cdc_pkg.sv
hw/rtl/cdc_ctrl.sv
hw/rtl/cdc_dpath.sv
hw/rtl/calendar_date_counter_unit.sv
tb/calendar_date_checker.sv
tb/tb_top.sv
